// ----- rtl/core/uvmm_pkg.sv -----
`timescale 1ns / 1ps

package uvmm_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = 7;
    localparam int DATA_W      = 32;
    localparam int OUT_BITS    = DATA_W + CNT_W + DATA_W + DATA_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Controller to datapath.
    typedef struct packed {
        logic              load_wr;   // store or drop an incoming word
        logic              p1_start;  // clear the singleton statistics
        logic              cap_vi;    // latch the element under test
        logic              scan;      // compare read data with the element under test
        logic              scan_end;  // last compare for this element
        logic              out_load;  // load a singleton result
        logic              out_none;  // load the none-found result
        logic              run_end;   // clear the fill count and overflow flag
        logic [ADDR_W-1:0] raddr;
        logic [ADDR_W-1:0] idx;
    } uvmm_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic [CNT_W-1:0] n;          // elements stored in this run
        logic             flag_i;     // element idx occurs once
        logic             has_unique;
        logic             out_last;   // result register holds the final result
    } uvmm_stat_t;

endpackage

// ----- rtl/core/uvmm_datapath.sv -----
`timescale 1ns / 1ps

module uvmm_datapath import uvmm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  uvmm_cmd_t              cmd,
    output uvmm_stat_t             stat,
    input  logic [DATA_W-1:0]      in_value,
    output logic [OUT_TDATA_W-1:0] out_tdata,
    output logic                   out_tlast,
    output logic [1:0]             out_tuser
);

    logic [DATA_W-1:0]      mem [MAX_ENTRIES];
    logic [DATA_W-1:0]      rdata_reg;
    logic [CNT_W-1:0]       loaded_reg;
    logic                   ovf_reg;
    logic [DATA_W-1:0]      vi_reg;
    logic [1:0]             hits_reg;
    logic [MAX_ENTRIES-1:0] flags_reg;
    logic [CNT_W-1:0]       ucnt_reg;
    logic [DATA_W-1:0]      max_reg;
    logic [DATA_W-1:0]      min_reg;
    logic [ADDR_W-1:0]      lastpos_reg;

    logic [DATA_W-1:0]      ov_value_reg;
    logic [CNT_W-1:0]       ov_cnt_reg;
    logic [DATA_W-1:0]      ov_max_reg;
    logic [DATA_W-1:0]      ov_min_reg;
    logic                   ov_last_reg;
    logic                   ov_none_reg;
    logic                   ov_ovf_reg;

    logic                   match;
    logic [1:0]             hits_sum;
    logic                   single;
    logic                   is_lastpos;
    logic                   store_full;

    assign store_full = (loaded_reg == CNT_W'(MAX_ENTRIES));
    assign match      = (rdata_reg == vi_reg);
    assign hits_sum   = (hits_reg == 2'd2) ? 2'd2 : hits_reg + {1'b0, match};
    assign single     = (hits_sum == 2'd1);
    assign is_lastpos = (cmd.idx == lastpos_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_wr && !store_full) begin
            mem[loaded_reg[ADDR_W-1:0]] <= in_value;
        end
        rdata_reg <= mem[cmd.raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= '0;
            ovf_reg    <= 1'b0;
        end else if (cmd.run_end) begin
            loaded_reg <= '0;
            ovf_reg    <= 1'b0;
        end else if (cmd.load_wr) begin
            if (store_full) begin
                ovf_reg <= 1'b1;
            end else begin
                loaded_reg <= loaded_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.p1_start) begin
            ucnt_reg <= '0;
            max_reg  <= '0;
            min_reg  <= '0;
        end
        if (cmd.cap_vi) begin
            vi_reg   <= rdata_reg;
            hits_reg <= 2'd0;
        end
        if (cmd.scan) begin
            hits_reg <= hits_sum;
            if (cmd.scan_end) begin
                flags_reg[cmd.idx] <= single;
                if (single) begin
                    ucnt_reg    <= ucnt_reg + 1'b1;
                    lastpos_reg <= cmd.idx;
                    if (ucnt_reg == '0) begin
                        max_reg <= vi_reg;
                        min_reg <= vi_reg;
                    end else begin
                        if ($signed(vi_reg) > $signed(max_reg)) begin
                            max_reg <= vi_reg;
                        end
                        if ($signed(vi_reg) < $signed(min_reg)) begin
                            min_reg <= vi_reg;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_none) begin
            ov_value_reg <= '0;
            ov_last_reg  <= 1'b1;
            ov_none_reg  <= 1'b1;
            ov_cnt_reg   <= '0;
            ov_max_reg   <= '0;
            ov_min_reg   <= '0;
            ov_ovf_reg   <= ovf_reg;
        end else if (cmd.out_load) begin
            ov_value_reg <= rdata_reg;
            ov_last_reg  <= is_lastpos;
            ov_none_reg  <= 1'b0;
            ov_cnt_reg   <= is_lastpos ? ucnt_reg : '0;
            ov_max_reg   <= is_lastpos ? max_reg : '0;
            ov_min_reg   <= is_lastpos ? min_reg : '0;
            ov_ovf_reg   <= ovf_reg;
        end
    end

    assign out_tdata = OUT_TDATA_W'({ov_min_reg, ov_max_reg, ov_cnt_reg, ov_value_reg});
    assign out_tlast = ov_last_reg;
    assign out_tuser = {ov_ovf_reg, ov_none_reg};

    assign stat.n          = loaded_reg;
    assign stat.flag_i     = flags_reg[cmd.idx];
    assign stat.has_unique = (ucnt_reg != '0);
    assign stat.out_last   = ov_last_reg;

endmodule

// ----- rtl/core/uvmm_ctrl.sv -----
`timescale 1ns / 1ps

module uvmm_ctrl import uvmm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic       in_last,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  uvmm_stat_t stat,
    output uvmm_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_P1_RDI,
        ST_P1_LDI,
        ST_P1_SCAN,
        ST_P2_RD,
        ST_P2_CHK,
        ST_P2_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic              i_last;
    logic              j_last;
    logic              accept;
    logic [CNT_W-1:0]  n_minus1;

    assign n_minus1 = stat.n - 1'b1;
    assign i_last   = (CNT_W'(i_reg) == n_minus1);
    assign j_last   = (CNT_W'(j_reg) == n_minus1);
    assign in_ready  = (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_P2_OUT);
    assign accept    = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.idx    = i_reg;
        cmd.raddr  = i_reg;
        case (state_reg)
            ST_LOAD: begin
                cmd.load_wr = accept;
                if (accept && in_last) begin
                    cmd.p1_start = 1'b1;
                    i_next       = '0;
                    state_next   = ST_P1_RDI;
                end
            end
            ST_P1_RDI: begin
                state_next = ST_P1_LDI;
            end
            ST_P1_LDI: begin
                cmd.cap_vi = 1'b1;
                cmd.raddr  = '0;
                j_next     = '0;
                state_next = ST_P1_SCAN;
            end
            ST_P1_SCAN: begin
                // Read data belongs to j; the next address goes out meanwhile.
                cmd.scan     = 1'b1;
                cmd.scan_end = j_last;
                cmd.raddr    = j_reg + 1'b1;
                j_next       = j_reg + 1'b1;
                if (j_last) begin
                    if (i_last) begin
                        i_next     = '0;
                        state_next = ST_P2_RD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_P1_RDI;
                    end
                end
            end
            ST_P2_RD: begin
                state_next = ST_P2_CHK;
            end
            ST_P2_CHK: begin
                if (!stat.has_unique) begin
                    cmd.out_none = 1'b1;
                    state_next   = ST_P2_OUT;
                end else if (stat.flag_i) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_P2_OUT;
                end else if (i_last) begin
                    cmd.run_end = 1'b1;
                    state_next  = ST_LOAD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_P2_RD;
                end
            end
            ST_P2_OUT: begin
                if (out_ready) begin
                    if (stat.out_last || i_last) begin
                        cmd.run_end = 1'b1;
                        state_next  = ST_LOAD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_P2_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

endmodule

// ----- rtl/core/unique_value_min_max_core.sv -----
`timescale 1ns / 1ps

// Channel | Ports                  | Word
// input   | s_tvalid/tready/tdata  | tdata[31:0] value, tlast last_value
// result  | m_tvalid/tready/tdata  | tdata: unique_value, unique_count, max, min;
//         | m_tlast, m_tuser       | tlast last_of_run; tuser none_found, overflowed
//
// Words before the last are stored as they arrive. On the last word, with n stored
// elements, the singleton pass compares each element with all n stored elements
// through the single read port of the value memory. The emit pass checks elements
// in turn up to the last singleton and emits each singleton, or a none-found result.
// No word is accepted while a data set is being evaluated or emitted.
// A stalled result holds in the output register until m_tready.
// Reset is synchronous, active low, and returns the block to loading.
module unique_value_min_max_core import uvmm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [31:0] value
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] unique_value, [38:32] unique_count, [70:39] max_value,
    // [102:71] min_value, [103] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic [1:0]             m_tuser    // [0] none_found, [1] overflowed
);

    uvmm_cmd_t  cmd;
    uvmm_stat_t stat;

    uvmm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    uvmm_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .in_value  (s_tdata),
        .out_tdata (m_tdata),
        .out_tlast (m_tlast),
        .out_tuser (m_tuser)
    );

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_none_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("none-found result not marked last");

    a_zero_count_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[38:32] == '0))
        else $error("count present on a non-final result");

    a_reload_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("block did not return to loading after the final result");

endmodule
